// ===== src/aspm_pkg.sv =====
`default_nettype none
package aspm_pkg;

  localparam int SPEED_W = 16;
  localparam int THR_W   = 10;
  localparam int KIND_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // sensor kind codes
  localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PITOT   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_VIRTUAL = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_KIND     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAILURE_THRESH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_THRESH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CHECK_SPEED = 2'd3;

  // configuration reset values
  localparam logic [KIND_W-1:0]  RST_SENSOR_KIND     = KIND_PITOT;
  localparam logic [THR_W-1:0]   RST_FAILURE_THRESH  = 10'd10;
  localparam logic [THR_W-1:0]   RST_RECOVERY_THRESH = 10'd100;
  localparam logic [SPEED_W-1:0] RST_MIN_CHECK_SPEED = 16'd700;

  // plausibility window: 0.3 * ref <= meas <= 2.0 * ref, done as 10*meas vs 3*ref
  localparam int PROD_W = SPEED_W + 4;
  localparam logic [PROD_W-1:0] LO_MEAS_SCALE = 20'd10;
  localparam logic [PROD_W-1:0] LO_REF_SCALE  = 20'd3;

  localparam logic [SPEED_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic               healthy;
    logic               calib_done;
    logic               armed;
    logic               gps_fix;
    logic [SPEED_W-1:0] measured_speed;
    logic [SPEED_W-1:0] reference_speed;
  } in_item_t;

  typedef struct packed {
    logic               speed_valid;
    logic               sensor_failed;
    logic [SPEED_W-1:0] speed_estimate;
  } out_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]  sensor_kind;
    logic [THR_W-1:0]   failure_threshold;
    logic [THR_W-1:0]   recovery_threshold;
    logic [SPEED_W-1:0] min_check_speed;
  } cfg_t;

endpackage
`default_nettype wire

// ===== src/aspm_monitor.sv =====
`default_nettype none
module aspm_monitor (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step_en,
  input  wire aspm_pkg::in_item_t item,
  input  wire aspm_pkg::cfg_t     cfg,
  output aspm_pkg::out_item_t     result
);

  logic                         failed_r, failed_nxt;
  logic [aspm_pkg::SPEED_W-1:0] fail_cnt_r, fail_cnt_nxt;
  logic [aspm_pkg::SPEED_W-1:0] rec_cnt_r, rec_cnt_nxt;

  logic                         base;
  logic                         ok;
  logic [aspm_pkg::PROD_W-1:0]  meas_x10;
  logic [aspm_pkg::PROD_W-1:0]  ref_x3;
  logic [aspm_pkg::SPEED_W:0]   ref_x2;
  logic [aspm_pkg::SPEED_W-1:0] fc1;
  logic [aspm_pkg::SPEED_W-1:0] rc1;
  logic [aspm_pkg::SPEED_W-1:0] rc2;
  logic                         ff1;
  logic                         valid;

  assign base     = item.healthy & item.calib_done;
  assign meas_x10 = aspm_pkg::PROD_W'(item.measured_speed) * aspm_pkg::LO_MEAS_SCALE;
  assign ref_x3   = aspm_pkg::PROD_W'(item.reference_speed) * aspm_pkg::LO_REF_SCALE;
  assign ref_x2   = {item.reference_speed, 1'b0};

  always_comb begin
    if (!item.gps_fix || item.reference_speed <= cfg.min_check_speed) begin
      ok = 1'b1;
    end else begin
      ok = (meas_x10 >= ref_x3) &&
           ((aspm_pkg::SPEED_W+1)'(item.measured_speed) <= ref_x2);
    end
  end

  always_comb begin
    // failure counter, saturating both ways
    if (!ok) begin
      fc1 = (fail_cnt_r == aspm_pkg::CNT_MAX) ? fail_cnt_r : fail_cnt_r + 1'b1;
    end else begin
      fc1 = (fail_cnt_r == '0) ? fail_cnt_r : fail_cnt_r - 1'b1;
    end

    if (fc1 >= aspm_pkg::SPEED_W'(cfg.failure_threshold)) begin
      ff1 = 1'b1;
      rc1 = '0;
    end else begin
      ff1 = failed_r;
      rc1 = rec_cnt_r;
    end

    rc2 = (rc1 == aspm_pkg::CNT_MAX) ? rc1 : rc1 + 1'b1;

    failed_nxt   = failed_r;
    fail_cnt_nxt = fail_cnt_r;
    rec_cnt_nxt  = rec_cnt_r;
    valid        = base;

    unique case (cfg.sensor_kind)
      aspm_pkg::KIND_VIRTUAL: begin
        valid = base & item.gps_fix;
      end
      aspm_pkg::KIND_NONE: begin
        valid = base;
      end
      default: begin
        // hardware pitot; the unused code behaves the same
        if (base) begin
          if (item.armed) begin
            failed_nxt   = ff1;
            fail_cnt_nxt = fc1;
            rec_cnt_nxt  = rc1;
            if (ff1) begin
              if (ok) begin
                rec_cnt_nxt = rc2;
                if (rc2 >= aspm_pkg::SPEED_W'(cfg.recovery_threshold)) begin
                  failed_nxt   = 1'b0;
                  fail_cnt_nxt = '0;
                  rec_cnt_nxt  = '0;
                end
              end else begin
                rec_cnt_nxt = '0;
              end
            end
          end else begin
            failed_nxt   = 1'b0;
            fail_cnt_nxt = '0;
            rec_cnt_nxt  = '0;
          end
          valid = failed_nxt ? item.gps_fix : 1'b1;
        end else begin
          valid = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      failed_r   <= 1'b0;
      fail_cnt_r <= '0;
      rec_cnt_r  <= '0;
    end else if (step_en) begin
      failed_r   <= failed_nxt;
      fail_cnt_r <= fail_cnt_nxt;
      rec_cnt_r  <= rec_cnt_nxt;
    end
  end

  // a stale failure flag from a previous kind still picks the reference
  assign result.speed_valid    = valid;
  assign result.sensor_failed  = failed_nxt;
  assign result.speed_estimate = (failed_nxt && item.reference_speed != '0) ?
                                 item.reference_speed : item.measured_speed;

endmodule
`default_nettype wire

// ===== src/airspeed_sensor_plausibility_monitor.sv =====
// data path: input register, then result register, from input beat to result beat
// throughput: one beat per cycle unless stalled; each step updates the failure state
// the input register holds one more beat while a finished result waits on out_stall
// reset: synchronous active-low rst_n clears both stages and the failure state,
// and loads the register defaults (pitot, 10, 100, 700 cm/s)
`default_nettype none
module airspeed_sensor_plausibility_monitor (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire aspm_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output aspm_pkg::out_item_t                  out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [aspm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [aspm_pkg::CFG_DATA_W-1:0] cfg_data
);

  aspm_pkg::cfg_t      cfg_r;
  logic                in_vld_r, in_vld_nxt;
  aspm_pkg::in_item_t  in_item_r;
  logic                out_vld_r, out_vld_nxt;
  aspm_pkg::out_item_t out_item_r;
  aspm_pkg::out_item_t step_result;
  logic                advance;
  logic                in_take;
  logic                step_en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sensor_kind        <= aspm_pkg::RST_SENSOR_KIND;
      cfg_r.failure_threshold  <= aspm_pkg::RST_FAILURE_THRESH;
      cfg_r.recovery_threshold <= aspm_pkg::RST_RECOVERY_THRESH;
      cfg_r.min_check_speed    <= aspm_pkg::RST_MIN_CHECK_SPEED;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        aspm_pkg::CFG_SENSOR_KIND: begin
          cfg_r.sensor_kind <= cfg_data[aspm_pkg::KIND_W-1:0];
        end
        aspm_pkg::CFG_FAILURE_THRESH: begin
          cfg_r.failure_threshold <= cfg_data[aspm_pkg::THR_W-1:0];
        end
        aspm_pkg::CFG_RECOVERY_THRESH: begin
          cfg_r.recovery_threshold <= cfg_data[aspm_pkg::THR_W-1:0];
        end
        aspm_pkg::CFG_MIN_CHECK_SPEED: begin
          cfg_r.min_check_speed <= cfg_data[aspm_pkg::SPEED_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // result register frees when empty or drained this cycle
  assign advance  = !out_vld_r || !out_stall;
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;
  assign step_en  = in_vld_r && advance;

  always_comb begin
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end else begin
      in_vld_nxt = in_vld_r;
    end
    out_vld_nxt = advance ? in_vld_r : out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_data;
    end
    if (step_en) begin
      out_item_r <= step_result;
    end
  end

  aspm_monitor u_monitor (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (in_item_r),
    .cfg     (cfg_r),
    .result  (step_result)
  );

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

endmodule
`default_nettype wire

// ===== src/aspm_checker.sv =====
`default_nettype none
module aspm_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire aspm_pkg::out_item_t out_data
);

  // a stalled result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // input only backs up when the result side is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with result side free");

  // an accepted beat reaches the result register when nothing blocks
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall ##1 (!out_valid || !out_stall) |=> out_valid)
    else $error("accepted beat did not reach the result register");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind airspeed_sensor_plausibility_monitor aspm_checker u_aspm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

// ===== bench/airspeed_sensor_plausibility_monitor_test.sv =====
`timescale 1ns / 100ps
module airspeed_sensor_plausibility_monitor_test;

  // code three has no name in the package; the block treats it as a pitot
  localparam logic [aspm_pkg::KIND_W-1:0] KIND_ALIAS_PITOT = 2'd3;
  localparam int STALL_LIMIT = 2000;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  aspm_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  aspm_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [aspm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [aspm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // register copy and failure state tracked beside the block
  logic [aspm_pkg::KIND_W-1:0] cur_kind;
  logic [aspm_pkg::THR_W-1:0] cur_fail_thr;
  logic [aspm_pkg::THR_W-1:0] cur_recover_thr;
  logic [aspm_pkg::SPEED_W-1:0] cur_min_speed;
  logic pm_failed;
  logic [aspm_pkg::SPEED_W-1:0] pm_fail_cnt;
  logic [aspm_pkg::SPEED_W-1:0] pm_recover_cnt;

  aspm_pkg::out_item_t pending_results[$];
  int unsigned idle_pct = 34;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  airspeed_sensor_plausibility_monitor u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit reading_in_window(aspm_pkg::in_item_t s);
    int unsigned m;
    int unsigned r;
    m = 32'(s.measured_speed);
    r = 32'(s.reference_speed);
    if (!s.gps_fix || s.reference_speed <= cur_min_speed) return 1'b1;
    return (10 * m >= 3 * r) && (m <= 2 * r);
  endfunction

  function automatic void clear_failure();
    pm_failed = 1'b0;
    pm_fail_cnt = '0;
    pm_recover_cnt = '0;
  endfunction

  // advances the tracked failure state by one sample and returns the result beat
  function automatic aspm_pkg::out_item_t judge_sample(aspm_pkg::in_item_t s);
    aspm_pkg::out_item_t res;
    bit ok;
    res.speed_valid = s.healthy & s.calib_done;
    if (cur_kind == aspm_pkg::KIND_VIRTUAL) begin
      res.speed_valid = res.speed_valid & s.gps_fix;
    end else if (res.speed_valid && cur_kind != aspm_pkg::KIND_NONE) begin
      if (s.armed) begin
        ok = reading_in_window(s);
        if (!ok) begin
          if (pm_fail_cnt != aspm_pkg::CNT_MAX) pm_fail_cnt = pm_fail_cnt + 1'b1;
        end else if (pm_fail_cnt != '0) begin
          pm_fail_cnt = pm_fail_cnt - 1'b1;
        end
        if (pm_fail_cnt >= aspm_pkg::SPEED_W'(cur_fail_thr)) begin
          pm_failed = 1'b1;
          pm_recover_cnt = '0;
        end
        if (pm_failed) begin
          if (ok) begin
            if (pm_recover_cnt != aspm_pkg::CNT_MAX) pm_recover_cnt = pm_recover_cnt + 1'b1;
            if (pm_recover_cnt >= aspm_pkg::SPEED_W'(cur_recover_thr)) clear_failure();
          end else begin
            pm_recover_cnt = '0;
          end
        end
      end else begin
        clear_failure();
      end
      if (pm_failed) res.speed_valid = res.speed_valid & s.gps_fix;
    end
    res.sensor_failed = pm_failed;
    res.speed_estimate = (pm_failed && s.reference_speed != '0) ? s.reference_speed
                                                                : s.measured_speed;
    return res;
  endfunction

  function automatic aspm_pkg::in_item_t make_sample(bit h, bit c, bit a, bit g,
                                                     logic [aspm_pkg::SPEED_W-1:0] m,
                                                     logic [aspm_pkg::SPEED_W-1:0] r);
    aspm_pkg::in_item_t s;
    s.healthy = h;
    s.calib_done = c;
    s.armed = a;
    s.gps_fix = g;
    s.measured_speed = m;
    s.reference_speed = r;
    return s;
  endfunction

  // mostly checked flight samples near the window; a quarter is raw noise
  function automatic aspm_pkg::in_item_t random_sample(int unsigned bad_pct);
    aspm_pkg::in_item_t s;
    int unsigned r;
    int unsigned lo;
    int unsigned hi;
    int unsigned pick;
    s = make_sample(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                    1'($urandom_range(1)), aspm_pkg::SPEED_W'($urandom_range(65535)),
                    aspm_pkg::SPEED_W'($urandom_range(65535)));
    if ($urandom_range(99) < 25) return s;
    s.healthy = 1'b1;
    s.calib_done = 1'b1;
    s.armed = ($urandom_range(99) >= 2);
    s.gps_fix = ($urandom_range(99) >= 8);
    if (cur_min_speed == aspm_pkg::CNT_MAX) r = $urandom_range(65535);
    else r = $urandom_range(65535, 32'(cur_min_speed) + 1);
    lo = (3 * r + 9) / 10;
    hi = (2 * r > 65535) ? 65535 : 2 * r;
    pick = $urandom_range(99);
    if (pick < 10) begin
      s.measured_speed = aspm_pkg::SPEED_W'(pick[0] ? lo : hi);
    end else if (pick < 20) begin
      if (pick[0] && lo > 0) s.measured_speed = aspm_pkg::SPEED_W'(lo - 1);
      else s.measured_speed = aspm_pkg::SPEED_W'((hi < 65535) ? hi + 1 : hi);
    end else if ($urandom_range(99) < bad_pct) begin
      if (lo > 0 && ($urandom_range(1) || hi == 65535))
        s.measured_speed = aspm_pkg::SPEED_W'($urandom_range(lo - 1, 0));
      else if (hi < 65535)
        s.measured_speed = aspm_pkg::SPEED_W'($urandom_range(65535, hi + 1));
      else s.measured_speed = aspm_pkg::SPEED_W'(lo);
    end else begin
      s.measured_speed = aspm_pkg::SPEED_W'($urandom_range(hi, lo));
    end
    s.reference_speed = aspm_pkg::SPEED_W'(r);
    return s;
  endfunction

  // returns right after the accepting edge with in_valid still high
  task automatic send_sample(aspm_pkg::in_item_t s);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(judge_sample(s));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [aspm_pkg::CFG_IDX_W-1:0] idx,
                           logic [aspm_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      aspm_pkg::CFG_SENSOR_KIND: cur_kind = val[aspm_pkg::KIND_W-1:0];
      aspm_pkg::CFG_FAILURE_THRESH: cur_fail_thr = val[aspm_pkg::THR_W-1:0];
      aspm_pkg::CFG_RECOVERY_THRESH: cur_recover_thr = val[aspm_pkg::THR_W-1:0];
      aspm_pkg::CFG_MIN_CHECK_SPEED: cur_min_speed = val[aspm_pkg::SPEED_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(logic [aspm_pkg::KIND_W-1:0] kind,
                           logic [aspm_pkg::THR_W-1:0] fail_thr,
                           logic [aspm_pkg::THR_W-1:0] recover_thr,
                           logic [aspm_pkg::SPEED_W-1:0] min_speed);
    drain();
    write_reg(aspm_pkg::CFG_SENSOR_KIND, aspm_pkg::CFG_DATA_W'(kind));
    write_reg(aspm_pkg::CFG_FAILURE_THRESH, aspm_pkg::CFG_DATA_W'(fail_thr));
    write_reg(aspm_pkg::CFG_RECOVERY_THRESH, aspm_pkg::CFG_DATA_W'(recover_thr));
    write_reg(aspm_pkg::CFG_MIN_CHECK_SPEED, aspm_pkg::CFG_DATA_W'(min_speed));
  endtask

  // reset register values, field extremes and the window edges
  task automatic test_reset_defaults();
    send_sample(make_sample(0, 0, 0, 0, 16'd0, 16'd0));
    send_sample(make_sample(1, 1, 1, 1, 16'hFFFF, 16'hFFFF));
    send_sample(make_sample(1, 0, 1, 1, 16'd100, 16'd1000));
    send_sample(make_sample(0, 1, 1, 1, 16'd100, 16'd1000));
    send_sample(make_sample(1, 1, 1, 1, 16'd0, 16'd700));
    send_sample(make_sample(1, 1, 1, 1, 16'd300, 16'd1000));
    send_sample(make_sample(1, 1, 1, 1, 16'd299, 16'd1000));
    send_sample(make_sample(1, 1, 1, 1, 16'd2000, 16'd1000));
    send_sample(make_sample(1, 1, 1, 1, 16'd2001, 16'd1000));
    send_sample(make_sample(1, 1, 1, 0, 16'd0, 16'd5000));
    send_sample(make_sample(1, 1, 0, 1, 16'd0, 16'd5000));
  endtask

  task automatic test_fail_and_recover();
    configure(aspm_pkg::KIND_PITOT, 10'd2, 10'd3, 16'd700);
    send_sample(make_sample(1, 1, 1, 1, 16'd0, 16'd5000));
    send_sample(make_sample(1, 1, 1, 1, 16'd9000, 16'd4000));
    // failed: no fix drops validity, zero reference falls back to measured
    send_sample(make_sample(1, 1, 1, 0, 16'd1234, 16'd5000));
    send_sample(make_sample(1, 1, 1, 1, 16'd1234, 16'd0));
    send_sample(make_sample(1, 1, 1, 1, 16'd5000, 16'd5000));
    send_sample(make_sample(1, 1, 1, 1, 16'd5000, 16'd5000));
    send_sample(make_sample(1, 1, 1, 1, 16'd0, 16'd5000));
    send_sample(make_sample(1, 1, 1, 1, 16'd0, 16'd5000));
    send_sample(make_sample(1, 1, 0, 1, 16'd5000, 16'd5000));
  endtask

  task automatic test_zero_thresholds();
    configure(aspm_pkg::KIND_PITOT, 10'd0, 10'd0, 16'd700);
    send_sample(make_sample(1, 1, 1, 1, 16'd0, 16'd5000));
    send_sample(make_sample(1, 1, 1, 1, 16'd5000, 16'd5000));
    send_sample(make_sample(1, 1, 1, 1, 16'd0, 16'd5000));
    configure(aspm_pkg::KIND_PITOT, 10'd1023, 10'd1023, 16'd0);
    send_sample(make_sample(1, 1, 1, 1, 16'd0, 16'd1));
  endtask

  // a failure flag left from pitot mode still picks the estimate in other modes
  task automatic test_sensor_kinds();
    configure(aspm_pkg::KIND_PITOT, 10'd1, 10'd1023, 16'd700);
    send_sample(make_sample(1, 1, 1, 1, 16'd0, 16'd5000));
    drain();
    write_reg(aspm_pkg::CFG_SENSOR_KIND, aspm_pkg::CFG_DATA_W'(aspm_pkg::KIND_VIRTUAL));
    send_sample(make_sample(1, 1, 1, 0, 16'd300, 16'd5000));
    send_sample(make_sample(1, 1, 0, 1, 16'd300, 16'd5000));
    drain();
    write_reg(aspm_pkg::CFG_SENSOR_KIND, aspm_pkg::CFG_DATA_W'(aspm_pkg::KIND_NONE));
    send_sample(make_sample(1, 1, 1, 0, 16'd300, 16'd6000));
    send_sample(make_sample(0, 1, 1, 1, 16'd300, 16'd6000));
    drain();
    write_reg(aspm_pkg::CFG_SENSOR_KIND, aspm_pkg::CFG_DATA_W'(KIND_ALIAS_PITOT));
    send_sample(make_sample(1, 1, 1, 1, 16'd0, 16'd5000));
    send_sample(make_sample(1, 1, 0, 1, 16'd0, 16'd5000));
  endtask

  // long run with no idling on either side: fail, then recover back to back
  task automatic test_back_to_back();
    configure(aspm_pkg::KIND_PITOT, 10'd4, 10'd6, 16'd700);
    idle_pct = 0;
    repeat (30) send_sample(make_sample(1, 1, 1, 1, 16'd0, 16'd5000));
    repeat (30) send_sample(make_sample(1, 1, 1, 1, 16'd5000, 16'd5000));
    idle_pct = 34;
  endtask

  task automatic test_random_flight();
    int unsigned bad_pct;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: configure(aspm_pkg::KIND_PITOT, 10'd1, 10'd1, 16'd0);
        1: configure(aspm_pkg::KIND_PITOT, 10'd1023, 10'd1023, 16'hFFFF);
        2: configure(KIND_ALIAS_PITOT, aspm_pkg::THR_W'($urandom_range(8, 1)),
                     aspm_pkg::THR_W'($urandom_range(12, 1)),
                     aspm_pkg::SPEED_W'($urandom_range(3000)));
        3: configure(aspm_pkg::KIND_W'($urandom_range(3)),
                     aspm_pkg::THR_W'($urandom_range(8, 1)),
                     aspm_pkg::THR_W'($urandom_range(12, 1)),
                     aspm_pkg::SPEED_W'($urandom_range(65535)));
        default: configure(aspm_pkg::KIND_PITOT, aspm_pkg::THR_W'($urandom_range(8, 1)),
                           aspm_pkg::THR_W'($urandom_range(12, 1)),
                           aspm_pkg::SPEED_W'($urandom_range(3000)));
      endcase
      bad_pct = 50;
      for (int n = 0; n < 85; n++) begin
        if (n % 25 == 0) begin
          case ($urandom_range(2))
            0: bad_pct = 5;
            1: bad_pct = 50;
            default: bad_pct = 95;
          endcase
        end
        send_sample(random_sample(bad_pct));
      end
    end
  endtask

  task automatic flag_field(string field, logic [31:0] exp_val, logic [31:0] got_val);
    mismatches++;
    $display("%0t: %s expected %0d actual %0d", $time, field, exp_val, got_val);
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  always @(posedge clk) begin
    aspm_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result beat %h", $time, out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data.speed_valid !== want.speed_valid)
          flag_field("speed_valid", 32'(want.speed_valid), 32'(out_data.speed_valid));
        if (out_data.sensor_failed !== want.sensor_failed)
          flag_field("sensor_failed", 32'(want.sensor_failed), 32'(out_data.sensor_failed));
        if (out_data.speed_estimate !== want.speed_estimate)
          flag_field("speed_estimate", 32'(want.speed_estimate),
                     32'(out_data.speed_estimate));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    cur_kind = aspm_pkg::RST_SENSOR_KIND;
    cur_fail_thr = aspm_pkg::RST_FAILURE_THRESH;
    cur_recover_thr = aspm_pkg::RST_RECOVERY_THRESH;
    cur_min_speed = aspm_pkg::RST_MIN_CHECK_SPEED;
    clear_failure();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_fail_and_recover();
    test_zero_thresholds();
    test_sensor_kinds();
    test_back_to_back();
    test_random_flight();
    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/aspm_pkg.sv
src/aspm_monitor.sv
src/airspeed_sensor_plausibility_monitor.sv
src/aspm_checker.sv
bench/airspeed_sensor_plausibility_monitor_test.sv
